@@ src/button_repeat_frequency_setter_defines.svh @@
// assertion macros for the button repeat frequency setter
// used by button_repeat_frequency_setter.sv, no other dependencies
`ifndef BUTTON_REPEAT_FREQUENCY_SETTER_DEFINES_SVH
`define BUTTON_REPEAT_FREQUENCY_SETTER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define BRFS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define BRFS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ src/brfs_pkg.sv @@
// shared types, widths and register codes for the button repeat frequency setter
// no dependencies
`timescale 1ns / 1ps

package brfs_pkg;

    localparam int TIME_BITS       = 32;
    localparam int STREAK_BITS     = 8;
    localparam int FREQ_BITS       = 14;
    localparam int STEP_BITS       = 8;
    localparam int GAP_BITS        = 16;
    localparam int TH_BITS         = 8;
    localparam int CFG_DATA_BITS   = 16;
    localparam int CFG_INDEX_BITS  = 3;
    localparam int NUM_BUTTONS     = 4;
    localparam int BTN_BITS        = 4;
    localparam int STREAK_CMP_BITS = (STREAK_BITS > TH_BITS) ? STREAK_BITS : TH_BITS;

    typedef logic [TIME_BITS-1:0]      t_time;
    typedef logic [STREAK_BITS-1:0]    t_streak;
    typedef logic [FREQ_BITS-1:0]      t_freq;
    typedef logic [STEP_BITS-1:0]      t_step;
    typedef logic [GAP_BITS-1:0]       t_gap;
    typedef logic [TH_BITS-1:0]        t_th;
    typedef logic [CFG_DATA_BITS-1:0]  t_cfg_data;
    typedef logic [CFG_INDEX_BITS-1:0] t_cfg_index;
    typedef logic [BTN_BITS-1:0]       t_buttons;

    localparam t_cfg_index REG_FIRST_DELAY = 3'd0;
    localparam t_cfg_index REG_FAST_GAP    = 3'd1;
    localparam t_cfg_index REG_STREAK_FAST = 3'd2;
    localparam t_cfg_index REG_BEEP_GAP    = 3'd3;
    localparam t_cfg_index REG_FREQ_MAX    = 3'd4;
    localparam t_cfg_index REG_FREQ_HOME   = 3'd5;
    localparam t_cfg_index REG_FREQ_STEP   = 3'd6;

    localparam t_gap  RST_FIRST_DELAY = 16'd250;
    localparam t_gap  RST_FAST_GAP    = 16'd1;
    localparam t_th   RST_STREAK_FAST = 8'd2;
    localparam t_gap  RST_BEEP_GAP    = 16'd500;
    localparam t_freq RST_FREQ_MAX    = 14'd8000;
    localparam t_freq RST_FREQ_HOME   = 14'd1000;
    localparam t_step RST_FREQ_STEP   = 8'd1;

    localparam int BTN_BEEP = 0;
    localparam int BTN_UP   = 1;
    localparam int BTN_DOWN = 2;
    localparam int BTN_HOME = 3;

endpackage

@@ src/button_repeat_frequency_setter.sv @@
// top level of the button repeat frequency setter: key auto-repeat with acceleration
// depends on brfs_pkg and button_repeat_frequency_setter_defines.svh
`timescale 1ns / 1ps

// Each accepted item (a millisecond time stamp and four active-low buttons) produces
// exactly one result item. An item waits in the input register, where the
// repeat decisions, frequency steps and beep request are worked out against the
// stored per-button state, and then sits in the output register until taken;
// one item is accepted every cycle while the output is not stalled. The rate
// rests on the combinational update of the button state and frequency register,
// written as each item moves on. Configuration registers may be written only
// while no item is in flight; they take effect for the next item.
module button_repeat_frequency_setter (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  brfs_pkg::t_cfg_index  i_cfg_index,
    input  brfs_pkg::t_cfg_data   i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  brfs_pkg::t_time       i_now_ms,
    input  brfs_pkg::t_buttons    i_buttons_n,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_short_beep,
    output brfs_pkg::t_freq       o_short_beep_freq,
    output logic                  o_long_beep,
    output brfs_pkg::t_freq       o_long_beep_freq,
    output brfs_pkg::t_freq       o_current_freq
);
    import brfs_pkg::*;
`include "button_repeat_frequency_setter_defines.svh"

    // configuration
    t_gap  r_first_delay;
    t_gap  r_fast_gap;
    t_th   r_streak_fast;
    t_gap  r_beep_gap;
    t_freq r_freq_max;
    t_freq r_freq_home;
    t_step r_freq_step;

    // state
    t_time   r_last_press [NUM_BUTTONS];
    t_streak r_streak     [NUM_BUTTONS];
    t_time   r_last_beep;
    t_freq   r_freq;

    // input register
    logic     r_s1_valid;
    t_time    r_s1_now;
    t_buttons r_s1_btn;

    // output register
    logic  r_out_valid;
    logic  r_out_short;
    t_freq r_out_short_freq;
    logic  r_out_long;
    t_freq r_out_long_freq;
    t_freq r_out_cur_freq;

    logic out_free;
    logic s1_go;
    logic s1_free;

    logic    accept       [NUM_BUTTONS];
    t_time   n_last_press [NUM_BUTTONS];
    t_streak n_streak     [NUM_BUTTONS];
    t_freq   freq_after   [NUM_BUTTONS];
    logic    beep_ok;
    logic    any_accept;
    logic    long_hit;
    t_freq   long_freq;
    t_time   n_last_beep;

    function automatic t_freq clamp_freq(input logic [FREQ_BITS:0] v, input t_freq fmax);
        t_freq res;
        res = (v > {1'b0, fmax}) ? fmax : v[FREQ_BITS-1:0];
        return res;
    endfunction

    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_go      = r_s1_valid && out_free;
    assign s1_free    = !r_s1_valid || out_free;
    assign o_in_stall = !s1_free;

    always_comb begin
        logic [STREAK_CMP_BITS-1:0] streak_ext;
        logic [STREAK_CMP_BITS-1:0] th_ext;
        t_time                      elapsed;
        logic                       pressed;
        logic [FREQ_BITS:0]         up_sum;
        logic [FREQ_BITS:0]         down_diff;
        th_ext = STREAK_CMP_BITS'(r_streak_fast);
        for (int k = 0; k < NUM_BUTTONS; k++) begin
            pressed    = !r_s1_btn[k];
            elapsed    = r_s1_now - r_last_press[k];
            streak_ext = STREAK_CMP_BITS'(r_streak[k]);
            accept[k]  = pressed && ((elapsed > TIME_BITS'(r_first_delay)) ||
                         ((elapsed > TIME_BITS'(r_fast_gap)) && (streak_ext > th_ext)));
            n_last_press[k] = accept[k] ? r_s1_now : r_last_press[k];
            if (accept[k]) begin
                n_streak[k] = (&r_streak[k]) ? r_streak[k] : r_streak[k] + 1'b1;
            end else if (!pressed) begin
                n_streak[k] = '0;
            end else begin
                n_streak[k] = r_streak[k];
            end
        end

        // frequency after each button in turn
        freq_after[BTN_BEEP] = r_freq;
        up_sum = {1'b0, freq_after[BTN_BEEP]} + (FREQ_BITS + 1)'(r_freq_step);
        freq_after[BTN_UP] = accept[BTN_UP] ?
            clamp_freq(up_sum, r_freq_max) : freq_after[BTN_BEEP];
        if (freq_after[BTN_UP] < FREQ_BITS'(r_freq_step)) begin
            down_diff = '0;
        end else begin
            down_diff = {1'b0, freq_after[BTN_UP] - FREQ_BITS'(r_freq_step)};
        end
        freq_after[BTN_DOWN] = accept[BTN_DOWN] ?
            clamp_freq(down_diff, r_freq_max) : freq_after[BTN_UP];
        freq_after[BTN_HOME] = accept[BTN_HOME] ? r_freq_home : freq_after[BTN_DOWN];

        // only the first accepted press can beep
        beep_ok    = (r_s1_now - r_last_beep) > TIME_BITS'(r_beep_gap);
        any_accept = accept[0] || accept[1] || accept[2] || accept[3];
        long_hit   = any_accept && beep_ok;
        if (!long_hit) begin
            long_freq = '0;
        end else if (accept[0]) begin
            long_freq = freq_after[0];
        end else if (accept[1]) begin
            long_freq = freq_after[1];
        end else if (accept[2]) begin
            long_freq = freq_after[2];
        end else begin
            long_freq = freq_after[3];
        end
        n_last_beep = long_hit ? r_s1_now : r_last_beep;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_delay <= RST_FIRST_DELAY;
            r_fast_gap    <= RST_FAST_GAP;
            r_streak_fast <= RST_STREAK_FAST;
            r_beep_gap    <= RST_BEEP_GAP;
            r_freq_max    <= RST_FREQ_MAX;
            r_freq_home   <= RST_FREQ_HOME;
            r_freq_step   <= RST_FREQ_STEP;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_FIRST_DELAY: r_first_delay <= i_cfg_data;
                REG_FAST_GAP:    r_fast_gap    <= i_cfg_data;
                REG_STREAK_FAST: r_streak_fast <= i_cfg_data[TH_BITS-1:0];
                REG_BEEP_GAP:    r_beep_gap    <= i_cfg_data;
                REG_FREQ_MAX:    r_freq_max    <= i_cfg_data[FREQ_BITS-1:0];
                REG_FREQ_HOME:   r_freq_home   <= i_cfg_data[FREQ_BITS-1:0];
                REG_FREQ_STEP:   r_freq_step   <= i_cfg_data[STEP_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_BUTTONS; k++) begin
                r_last_press[k] <= '0;
                r_streak[k]     <= '0;
            end
            r_last_beep <= '0;
            r_freq      <= RST_FREQ_HOME;
        end else if (s1_go) begin
            for (int k = 0; k < NUM_BUTTONS; k++) begin
                r_last_press[k] <= n_last_press[k];
                r_streak[k]     <= n_streak[k];
            end
            r_last_beep <= n_last_beep;
            r_freq      <= freq_after[BTN_HOME];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_free && i_in_valid) begin
            r_s1_now <= i_now_ms;
            r_s1_btn <= i_buttons_n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_out_short      <= !r_s1_btn[BTN_BEEP];
            r_out_short_freq <= r_freq;
            r_out_long       <= long_hit;
            r_out_long_freq  <= long_freq;
            r_out_cur_freq   <= freq_after[BTN_HOME];
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_short_beep      = r_out_short;
    assign o_short_beep_freq = r_out_short_freq;
    assign o_long_beep       = r_out_long;
    assign o_long_beep_freq  = r_out_long_freq;
    assign o_current_freq    = r_out_cur_freq;

    `BRFS_ASSERT_NOW(a_no_long_no_freq, o_out_valid && !o_long_beep, o_long_beep_freq == '0, "long beep freq without long beep")
    `BRFS_ASSERT_NOW(a_stall_only_full, o_in_stall, r_s1_valid && r_out_valid && i_out_stall, "input stalled while room is free")
    `BRFS_ASSERT_NEXT(a_go_fills_out, s1_go, r_out_valid, "item lost between input and output register")
    `BRFS_ASSERT_NEXT(a_beep_stamp, s1_go && long_hit, r_last_beep == $past(r_s1_now), "beep time stamp not updated")

endmodule

@@ dv/button_repeat_frequency_setter_test.sv @@
// self-checking testbench for button_repeat_frequency_setter: directed table then random holds
// expects typed rows' listed results, predicts other items in-line; compares field by field; depends on brfs_pkg
`timescale 1ns / 1ps

module button_repeat_frequency_setter_test;
    import brfs_pkg::*;

    localparam t_cfg_index REG_UNUSED = 3'd7;
    localparam int HALF_NS      = 6;
    localparam int RESET_CYCLES = 4;
    localparam int DRAIN_CYCLES = 4;
    localparam int LIMIT_NS     = 5_000_000;
    localparam int NUM_PHASES   = 5;

    typedef struct packed {
        logic  short_beep;
        t_freq short_freq;
        logic  long_beep;
        t_freq long_freq;
        t_freq cur_freq;
    } t_beep_result;

    typedef enum logic {ROW_ITEM, ROW_WRITE} t_row_kind;

    typedef struct packed {
        t_row_kind    kind;
        logic         typed;
        t_time        now;
        t_buttons     btn_n;
        t_cfg_index   idx;
        t_cfg_data    data;
        t_beep_result want;
    } t_stim_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    t_cfg_index i_cfg_index;
    t_cfg_data  i_cfg_data;
    logic       i_in_valid;
    logic       o_in_stall;
    t_time      i_now_ms;
    t_buttons   i_buttons_n;
    logic       o_out_valid;
    logic       i_out_stall;
    logic       o_short_beep;
    t_freq      o_short_beep_freq;
    logic       o_long_beep;
    t_freq      o_long_beep_freq;
    t_freq      o_current_freq;

    // predicted copy of the configuration
    t_gap  first_delay;
    t_gap  fast_gap;
    t_th   streak_fast;
    t_gap  beep_gap;
    t_freq freq_max;
    t_freq freq_home;
    t_step freq_step;

    // predicted copy of the button and frequency state
    t_time   press_ms [NUM_BUTTONS];
    t_streak streak_cnt [NUM_BUTTONS];
    t_time   beep_ms;
    t_freq   freq_q;

    t_beep_result pending_beeps [$];
    t_stim_row    script_rows [$];
    int           mismatches;
    bit           in_calm;
    bit           out_calm;
    t_time        cursor_ms;
    t_buttons     hold_pressed;
    int           hold_left;

    button_repeat_frequency_setter u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_now_ms          (i_now_ms),
        .i_buttons_n       (i_buttons_n),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_short_beep      (o_short_beep),
        .o_short_beep_freq (o_short_beep_freq),
        .o_long_beep       (o_long_beep),
        .o_long_beep_freq  (o_long_beep_freq),
        .o_current_freq    (o_current_freq)
    );

    always begin
        #HALF_NS i_clk = 1'b1;
        #HALF_NS i_clk = 1'b0;
    end

    function automatic t_freq freq_limit(input int f);
        return (f > int'(freq_max)) ? freq_max : t_freq'(f);
    endfunction

    function automatic void apply_reg(input t_cfg_index idx, input t_cfg_data data);
        case (idx)
            REG_FIRST_DELAY: first_delay = data;
            REG_FAST_GAP:    fast_gap    = data;
            REG_STREAK_FAST: streak_fast = data[TH_BITS-1:0];
            REG_BEEP_GAP:    beep_gap    = data;
            REG_FREQ_MAX:    freq_max    = data[FREQ_BITS-1:0];
            REG_FREQ_HOME:   freq_home   = data[FREQ_BITS-1:0];
            REG_FREQ_STEP:   freq_step   = data[STEP_BITS-1:0];
            default: ;
        endcase
    endfunction

    // buttons in order 0 to 3, updating the predicted state
    function automatic t_beep_result step_buttons(input t_time now, input t_buttons btn_n);
        t_beep_result r;
        t_time        since;
        t_time        since_beep;
        logic         held;
        logic         take;
        r.short_beep = !btn_n[BTN_BEEP];
        r.short_freq = freq_q;
        r.long_beep  = 1'b0;
        r.long_freq  = '0;
        for (int k = 0; k < NUM_BUTTONS; k++) begin
            held  = !btn_n[k];
            since = now - press_ms[k];
            take  = held && (since > t_time'(first_delay) ||
                    (since > t_time'(fast_gap) && streak_cnt[k] > streak_fast));
            if (take) begin
                press_ms[k] = now;
                if (streak_cnt[k] != '1) begin
                    streak_cnt[k] = streak_cnt[k] + 1'b1;
                end
                if (k == BTN_UP) begin
                    freq_q = freq_limit(int'(freq_q) + int'(freq_step));
                end else if (k == BTN_DOWN) begin
                    freq_q = freq_limit((freq_q < t_freq'(freq_step)) ? 0 :
                                        int'(freq_q) - int'(freq_step));
                end else if (k == BTN_HOME) begin
                    freq_q = freq_home;
                end
                since_beep = now - beep_ms;
                if (since_beep > t_time'(beep_gap)) begin
                    beep_ms     = now;
                    r.long_beep = 1'b1;
                    r.long_freq = freq_q;
                end
            end else if (!held) begin
                streak_cnt[k] = '0;
            end
        end
        r.cur_freq = freq_q;
        return r;
    endfunction

    function automatic void add_item(input t_time now, input t_buttons btn_n);
        t_stim_row row;
        row       = '0;
        row.kind  = ROW_ITEM;
        row.now   = now;
        row.btn_n = btn_n;
        script_rows.push_back(row);
    endfunction

    function automatic void add_checked(input t_time now, input t_buttons btn_n,
                                        input logic sb, input t_freq sf, input logic lb,
                                        input t_freq lf, input t_freq cf);
        t_stim_row row;
        row            = '0;
        row.kind       = ROW_ITEM;
        row.typed      = 1'b1;
        row.now        = now;
        row.btn_n      = btn_n;
        row.want       = {sb, sf, lb, lf, cf};
        script_rows.push_back(row);
    endfunction

    function automatic void add_write(input t_cfg_index idx, input t_cfg_data data);
        t_stim_row row;
        row      = '0;
        row.kind = ROW_WRITE;
        row.idx  = idx;
        row.data = data;
        script_rows.push_back(row);
    endfunction

    function automatic t_time pick_step();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0, 1, 2, 3: return t_time'($urandom_range(0, 3));
            4: return t_time'(fast_gap) + t_time'($urandom_range(0, 2)) - t_time'(1);
            5, 6: return t_time'(first_delay) + t_time'($urandom_range(0, 2)) - t_time'(1);
            7: return t_time'(beep_gap) + t_time'($urandom_range(0, 2)) - t_time'(1);
            8: return t_time'($urandom_range(0, 700));
            default: return t_time'($urandom());
        endcase
    endfunction

    // runs of held buttons with random timing, broken by releases and noise
    task automatic next_item(input bit hold_beep, output t_time now, output t_buttons btn_n);
        t_buttons pressed;
        t_time    dt;
        int       pick;
        if (hold_left == 0) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                hold_pressed = t_buttons'($urandom_range(0, 15));
                hold_left    = 1;
            end else if (pick < 3) begin
                hold_pressed = '0;
                hold_left    = $urandom_range(1, 3);
            end else begin
                hold_pressed = t_buttons'($urandom_range(1, 15));
                hold_left    = $urandom_range(1, 24);
            end
        end
        hold_left = hold_left - 1;
        dt = pick_step();
        if (hold_beep && dt == 0) begin
            dt = 1;
        end
        cursor_ms = cursor_ms + dt;
        pressed   = hold_pressed;
        if (hold_beep) begin
            pressed[BTN_BEEP] = 1'b1;
        end
        now   = cursor_ms;
        btn_n = ~pressed;
    endtask

    task automatic send_item(input t_time now, input t_buttons btn_n, input logic typed,
                             input t_beep_result want);
        int           gap;
        t_beep_result calc;
        if ($urandom_range(0, 15) == 0) begin
            in_calm = !in_calm;
        end
        gap = in_calm ? 0 : $urandom_range(0, 7);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid  = 1'b1;
        i_now_ms    = now;
        i_buttons_n = btn_n;
        do @(posedge i_clk); while (o_in_stall);
        calc = step_buttons(now, btn_n);
        pending_beeps.push_back(typed ? want : calc);
    endtask

    task automatic write_reg(input t_cfg_index idx, input t_cfg_data data);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_beeps.size() != 0) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        apply_reg(idx, data);
    endtask

    task automatic set_all(input t_cfg_data first, input t_cfg_data fast,
                           input t_cfg_data streak, input t_cfg_data beep,
                           input t_cfg_data fmax, input t_cfg_data home,
                           input t_cfg_data step);
        write_reg(REG_FIRST_DELAY, first);
        write_reg(REG_FAST_GAP, fast);
        write_reg(REG_STREAK_FAST, streak);
        write_reg(REG_BEEP_GAP, beep);
        write_reg(REG_FREQ_MAX, fmax);
        write_reg(REG_FREQ_HOME, home);
        write_reg(REG_FREQ_STEP, step);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    initial begin
        t_stim_row row;
        t_time     now;
        t_buttons  btn_n;
        int        n_items;
        int        n_force;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = REG_FIRST_DELAY;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_now_ms     = '0;
        i_buttons_n  = '1;
        i_out_stall  = 1'b0;
        mismatches   = 0;
        in_calm      = 1'b0;
        out_calm     = 1'b0;
        hold_pressed = '0;
        hold_left    = 0;
        first_delay  = RST_FIRST_DELAY;
        fast_gap     = RST_FAST_GAP;
        streak_fast  = RST_STREAK_FAST;
        beep_gap     = RST_BEEP_GAP;
        freq_max     = RST_FREQ_MAX;
        freq_home    = RST_FREQ_HOME;
        freq_step    = RST_FREQ_STEP;
        for (int k = 0; k < NUM_BUTTONS; k++) begin
            press_ms[k]   = '0;
            streak_cnt[k] = '0;
        end
        beep_ms = '0;
        freq_q  = RST_FREQ_HOME;

        // after reset: idle, short beep below first delay, first repeat without long beep
        add_checked(32'd0, 4'hF, 1'b0, 14'd1000, 1'b0, 14'd0, 14'd1000);
        add_checked(32'd100, 4'hE, 1'b1, 14'd1000, 1'b0, 14'd0, 14'd1000);
        add_checked(32'd251, 4'hE, 1'b1, 14'd1000, 1'b0, 14'd0, 14'd1000);
        add_checked(32'd600, 4'hD, 1'b0, 14'd1000, 1'b1, 14'd1001, 14'd1001);
        // normal repeat, then fast repeat once the streak passes its threshold
        add_item(32'd851, 4'hD);
        add_item(32'd1102, 4'hD);
        add_item(32'd1104, 4'hD);
        add_item(32'd1105, 4'hD);
        add_item(32'd1107, 4'h9);
        add_item(32'd1200, 4'hF);
        add_item(32'd2000, 4'h7);
        // all pressed: only the first accepted press beeps
        add_item(32'd3000, 4'h0);
        // frequency above a lowered maximum
        add_write(REG_FREQ_MAX, 16'd100);
        add_checked(32'd4000, 4'hD, 1'b0, 14'd1000, 1'b1, 14'd100, 14'd100);
        add_checked(32'd5000, 4'h7, 1'b0, 14'd100, 1'b1, 14'd1000, 14'd1000);
        add_checked(32'd6000, 4'hB, 1'b0, 14'd1000, 1'b1, 14'd100, 14'd100);
        // widest frequency and step, saturation at both ends
        add_write(REG_FREQ_HOME, 16'hFFFF);
        add_write(REG_FREQ_MAX, 16'hFFFF);
        add_write(REG_FREQ_STEP, 16'hFFFF);
        add_checked(32'd7000, 4'h7, 1'b0, 14'd100, 1'b1, 14'd16383, 14'd16383);
        add_checked(32'd8000, 4'hD, 1'b0, 14'd16383, 1'b1, 14'd16383, 14'd16383);
        add_write(REG_FREQ_HOME, 16'd0);
        add_checked(32'd9000, 4'h7, 1'b0, 14'd16383, 1'b1, 14'd0, 14'd0);
        add_checked(32'd10000, 4'hB, 1'b0, 14'd0, 1'b1, 14'd0, 14'd0);
        // ignored register index, zero gaps, time wrap
        add_write(REG_UNUSED, 16'hFFFF);
        add_write(REG_BEEP_GAP, 16'd0);
        add_write(REG_FIRST_DELAY, 16'd0);
        add_checked(32'hFFFF_FFFF, 4'hE, 1'b1, 14'd0, 1'b1, 14'd0, 14'd0);
        add_checked(32'd0, 4'hE, 1'b1, 14'd0, 1'b1, 14'd0, 14'd0);
        add_checked(32'd0, 4'hE, 1'b1, 14'd0, 1'b0, 14'd0, 14'd0);
        add_write(REG_FAST_GAP, 16'd0);
        add_write(REG_STREAK_FAST, 16'd0);
        add_checked(32'd0, 4'hE, 1'b1, 14'd0, 1'b0, 14'd0, 14'd0);
        add_item(32'h8000_0000, 4'h0);
        add_item(32'h7FFF_FFFF, 4'hF);

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (script_rows[i]) begin
            row = script_rows[i];
            if (row.kind == ROW_WRITE) begin
                write_reg(row.idx, row.data);
            end else begin
                send_item(row.now, row.btn_n, row.typed, row.want);
            end
        end

        cursor_ms = 32'h7FFF_FFFF;
        for (int p = 0; p < NUM_PHASES; p++) begin
            n_force = 0;
            case (p)
                0: begin
                    // button 0 held long enough to saturate its streak
                    set_all(16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
                    n_items = 260;
                    n_force = 260;
                end
                1: begin
                    // fast repeat only works if the streak stuck at its maximum
                    set_all(16'hFFFF, 16'd0, 16'd254, 16'hFFFF, 16'd8000, 16'd16383, 16'd1);
                    n_items = 40;
                    n_force = 20;
                end
                2: begin
                    set_all(t_cfg_data'(RST_FIRST_DELAY), t_cfg_data'(RST_FAST_GAP),
                            t_cfg_data'(RST_STREAK_FAST), t_cfg_data'(RST_BEEP_GAP),
                            t_cfg_data'(RST_FREQ_MAX), t_cfg_data'(RST_FREQ_HOME),
                            t_cfg_data'(RST_FREQ_STEP));
                    n_items = 60;
                end
                3: begin
                    set_all(t_cfg_data'($urandom_range(0, 600)),
                            t_cfg_data'($urandom_range(0, 20)),
                            t_cfg_data'($urandom_range(0, 8)),
                            t_cfg_data'($urandom_range(0, 1000)),
                            t_cfg_data'($urandom_range(0, 16383)),
                            t_cfg_data'($urandom_range(0, 16383)),
                            t_cfg_data'($urandom_range(0, 255)));
                    n_items = 50;
                end
                default: begin
                    set_all(t_cfg_data'($urandom()), t_cfg_data'($urandom()),
                            t_cfg_data'($urandom()), t_cfg_data'($urandom()),
                            t_cfg_data'($urandom_range(0, 200)), t_cfg_data'($urandom()),
                            t_cfg_data'($urandom()));
                    n_items = 50;
                end
            endcase
            for (int i = 0; i < n_items; i++) begin
                next_item(i < n_force, now, btn_n);
                send_item(now, btn_n, 1'b0, '0);
            end
        end

        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_beeps.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("button_repeat_frequency_setter_test OK");
        end else begin
            $display("button_repeat_frequency_setter_test NOT OK");
        end
        $finish;
    end

    // result side: random stall, then take and compare one item
    initial begin
        t_beep_result want;
        int           hold;
        wait (i_rst_n === 1'b1);
        forever begin
            if ($urandom_range(0, 15) == 0) begin
                out_calm = !out_calm;
            end
            hold = out_calm ? 0 : $urandom_range(0, 7);
            @(negedge i_clk);
            if (hold > 0) begin
                i_out_stall = 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_out_stall = 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            if (pending_beeps.size() == 0) begin
                $error("result item with no expected result waiting");
                mismatches++;
            end else begin
                want = pending_beeps.pop_front();
                check_field("short_beep", int'(want.short_beep), int'(o_short_beep));
                check_field("short_beep_freq", int'(want.short_freq),
                            int'(o_short_beep_freq));
                check_field("long_beep", int'(want.long_beep), int'(o_long_beep));
                check_field("long_beep_freq", int'(want.long_freq), int'(o_long_beep_freq));
                check_field("current_freq", int'(want.cur_freq), int'(o_current_freq));
            end
        end
    end

    initial begin
        #LIMIT_NS;
        $display("button_repeat_frequency_setter_test NOT OK");
        $finish;
    end

endmodule

@@ button_repeat_frequency_setter.f @@
+incdir+src
src/brfs_pkg.sv
src/button_repeat_frequency_setter.sv
dv/button_repeat_frequency_setter_test.sv
